// File: sv/slps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package slps_pkg;

   localparam int LEVEL_MAX_DEFAULT = 64;

   localparam int COLOR_W     = 8;
   localparam int STEP_W      = 8;
   localparam int HOLD_W      = 10;
   localparam int PROD_W      = 2 * COLOR_W;
   localparam int STATUS_W    = 3;
   localparam int ACTION_W    = 2;
   localparam int CSR_DATA_W  = 10;
   localparam int CSR_INDEX_W = 3;
   localparam int BLINK_IDX_W = 5;
   localparam int BLINK_LEN_W = 3;

   typedef enum logic [ACTION_W-1:0] {
      ACT_TICK   = 2'd0,
      ACT_STATUS = 2'd1,
      ACT_SETUP  = 2'd2,
      ACT_WIFI   = 2'd3
   } action_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NORMAL_RED   = 3'd0,
      CSR_NORMAL_GREEN = 3'd1,
      CSR_NORMAL_BLUE  = 3'd2,
      CSR_NORMAL_STEP  = 3'd3,
      CSR_SETUP_STEP   = 3'd4
   } csr_index_type;

   localparam logic [STATUS_W-1:0] STATUS_BOOT         = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_USB_ATTACHED = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_USB_DETACHED = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_ERROR        = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_QUEUE_WAIT   = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_WIFI_DOWN    = 3'd5;

   typedef enum logic [3:0] {
      PAT_NONE      = 4'd0,
      PAT_ENTRY     = 4'd1,
      PAT_SETUP0    = 4'd2,
      PAT_SETUP1    = 4'd3,
      PAT_SETUP2    = 4'd4,
      PAT_SETUP3    = 4'd5,
      PAT_NORM_UP   = 4'd6,
      PAT_NORM_DOWN = 4'd7,
      PAT_WIFI      = 4'd8,
      PAT_BOOT      = 4'd9,
      PAT_ERROR     = 4'd10,
      PAT_QUEUE     = 4'd11,
      PAT_IDLE      = 4'd12
   } pattern_type;

   typedef struct packed {
      logic [COLOR_W-1:0] normal_red;
      logic [COLOR_W-1:0] normal_green;
      logic [COLOR_W-1:0] normal_blue;
      logic [HOLD_W-1:0]  normal_step;
      logic [HOLD_W-1:0]  setup_step;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      normal_red:   8'd6,
      normal_green: 8'd87,
      normal_blue:  8'd33,
      normal_step:  10'd40,
      setup_step:   10'd30
   };

   // Color update for one request. Scaled channels still need the division by
   // the ramp's full level; the others carry the color in their low byte.
   typedef struct packed {
      logic              write;
      logic              scaled;
      logic [PROD_W-1:0] r;
      logic [PROD_W-1:0] g;
      logic [PROD_W-1:0] b;
   } paint_type;

   typedef struct packed {
      logic               write;
      logic [COLOR_W-1:0] r;
      logic [COLOR_W-1:0] g;
      logic [COLOR_W-1:0] b;
      logic [HOLD_W-1:0]  hold_ms;
   } blink_type;

   function automatic blink_type blink_entry(input logic [BLINK_IDX_W-1:0] idx);
      blink_type s;
      unique case (idx)
         5'd0, 5'd2, 5'd4: s = '{1'b1, 8'd0,  8'd0,  8'd64, 10'd120};
         5'd1, 5'd3, 5'd5: s = '{1'b1, 8'd0,  8'd0,  8'd0,  10'd120};
         5'd6:             s = '{1'b1, 8'd96, 8'd0,  8'd24, 10'd200};
         5'd7:             s = '{1'b1, 8'd0,  8'd0,  8'd0,  10'd800};
         5'd8:             s = '{1'b1, 8'd0,  8'd64, 8'd0,  10'd50};
         5'd9:             s = '{1'b1, 8'd0,  8'd0,  8'd0,  10'd500};
         5'd10, 5'd12:     s = '{1'b1, 8'd64, 8'd0,  8'd0,  10'd100};
         5'd11:            s = '{1'b1, 8'd0,  8'd0,  8'd0,  10'd200};
         5'd13:            s = '{1'b1, 8'd0,  8'd0,  8'd0,  10'd800};
         5'd14:            s = '{1'b1, 8'd48, 8'd0,  8'd48, 10'd150};
         5'd15:            s = '{1'b1, 8'd0,  8'd0,  8'd0,  10'd500};
         default:          s = '{1'b0, 8'd0,  8'd0,  8'd0,  10'd500};
      endcase
      return s;
   endfunction

   function automatic logic [BLINK_IDX_W-1:0] blink_start(input pattern_type p);
      logic [BLINK_IDX_W-1:0] start;
      unique case (p)
         PAT_ENTRY: start = 5'd0;
         PAT_WIFI:  start = 5'd6;
         PAT_BOOT:  start = 5'd8;
         PAT_ERROR: start = 5'd10;
         PAT_QUEUE: start = 5'd14;
         default:   start = 5'd16;
      endcase
      return start;
   endfunction

   function automatic logic [BLINK_LEN_W-1:0] blink_len(input pattern_type p);
      logic [BLINK_LEN_W-1:0] len;
      unique case (p)
         PAT_ENTRY: len = 3'd6;
         PAT_WIFI:  len = 3'd2;
         PAT_BOOT:  len = 3'd2;
         PAT_ERROR: len = 3'd4;
         PAT_QUEUE: len = 3'd2;
         default:   len = 3'd1;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

// File: sv/status_led_pattern_sequencer_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    req_action, req_value
// rsp       out        rsp_valid/rsp_ready    rsp_red, rsp_green, rsp_blue, rsp_refresh
// csr       in         csr_wen (no wait)      csr_index, csr_wdata
//
// One request is taken every cycle unless a stalled response fills both stages; each
// response is registered first in the sequencer stage and then in the color stage.
// The pattern state advances in the sequencer stage; the normal breathe color
// is scaled by a constant reciprocal multiply in the color stage.
// Reset clears the pattern state, the LED color to black and the registers
// to their defaults. A stalled response holds the color stage, and the
// sequencer stage still takes a request while its own register is free.

module status_led_pattern_sequencer_unit
   import slps_pkg::*;
#(
   parameter int LEVEL_MAX = LEVEL_MAX_DEFAULT
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [ACTION_W-1:0]    req_action,
   input  wire logic [STATUS_W-1:0]    req_value,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [COLOR_W-1:0]          rsp_red,
   output logic [COLOR_W-1:0]          rsp_green,
   output logic [COLOR_W-1:0]          rsp_blue,
   output logic                        rsp_refresh,
   input  wire logic                   csr_wen,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type   cfg_ff, cfg_in;
   logic      s1_valid_ff, s1_valid_in;
   paint_type s1_paint_ff;
   paint_type paint;
   logic      accept;
   logic      take;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index_type'(csr_index))
            CSR_NORMAL_RED:   cfg_in.normal_red   = csr_wdata[COLOR_W-1:0];
            CSR_NORMAL_GREEN: cfg_in.normal_green = csr_wdata[COLOR_W-1:0];
            CSR_NORMAL_BLUE:  cfg_in.normal_blue  = csr_wdata[COLOR_W-1:0];
            CSR_NORMAL_STEP:  cfg_in.normal_step  = csr_wdata[HOLD_W-1:0];
            CSR_SETUP_STEP:   cfg_in.setup_step   = csr_wdata[HOLD_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   assign req_ready   = ~s1_valid_ff | take;
   assign accept      = req_valid & req_ready;
   assign s1_valid_in = accept | (s1_valid_ff & ~take);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff      <= CFG_RESET;
         s1_valid_ff <= 1'b0;
      end else begin
         cfg_ff      <= cfg_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_paint_ff <= paint;
      end
   end

   slps_seq #(
      .LEVEL_MAX (LEVEL_MAX)
   ) u_seq (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .action (req_action),
      .value  (req_value),
      .cfg    (cfg_ff),
      .paint  (paint)
   );

   slps_color #(
      .LEVEL_MAX (LEVEL_MAX)
   ) u_color (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s1_valid_ff),
      .paint       (s1_paint_ff),
      .take        (take),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_red     (rsp_red),
      .rsp_green   (rsp_green),
      .rsp_blue    (rsp_blue),
      .rsp_refresh (rsp_refresh)
   );

endmodule

`default_nettype wire

// File: sv/slps_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module slps_seq
   import slps_pkg::*;
#(
   parameter int LEVEL_MAX = LEVEL_MAX_DEFAULT
)
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire logic [ACTION_W-1:0] action,
   input  wire logic [STATUS_W-1:0] value,
   input  wire cfg_type             cfg,
   output paint_type                paint
);

   localparam int RAMP_STEPS = LEVEL_MAX / 2 + 1;
   localparam logic [STEP_W-1:0]  RAMP_END  = STEP_W'(RAMP_STEPS);
   localparam logic [COLOR_W-1:0] LEVEL_TOP = COLOR_W'(LEVEL_MAX);

   logic [STATUS_W-1:0] status_ff, status_in;
   logic                setup_ff, setup_in;
   logic                entry_ff, entry_in;
   logic                wifi_down_ff, wifi_down_in;
   pattern_type         pat_ff, pat_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [HOLD_W-1:0]   ms_left_ff, ms_left_in;

   logic                ramp_end;
   logic                last_ramp;
   logic                blink_end;
   logic                entry_next;
   logic [STATUS_W-1:0] status_next;
   pattern_type         cand_pat;
   logic [STEP_W-1:0]   cand_step;
   logic                need_pick;
   pattern_type         exec_pat;
   logic [STEP_W-1:0]   exec_step;
   logic                exec_ramp;
   logic                exec_up;
   logic [COLOR_W-1:0]  level;
   blink_type           blink;
   logic [HOLD_W-1:0]   hold;
   paint_type           exec_paint;

   function automatic logic is_ramp(input pattern_type p);
      return (p >= PAT_SETUP0) && (p <= PAT_NORM_DOWN);
   endfunction

   function automatic logic is_setup_ramp(input pattern_type p);
      return (p >= PAT_SETUP0) && (p <= PAT_SETUP3);
   endfunction

   function automatic logic is_blink(input pattern_type p);
      return (p == PAT_ENTRY) || ((p >= PAT_WIFI) && (p <= PAT_IDLE));
   endfunction

   function automatic logic [HOLD_W-1:0] step_len(input logic [HOLD_W-1:0] v);
      return (v == '0) ? HOLD_W'(1) : v;
   endfunction

   function automatic pattern_type pick_pattern(input logic                setup,
                                                input logic                entry,
                                                input logic                wifi,
                                                input logic [STATUS_W-1:0] status);
      pattern_type p;
      if (setup) begin
         p = entry ? PAT_ENTRY : PAT_SETUP0;
      end else if (wifi) begin
         p = PAT_WIFI;
      end else begin
         unique case (status)
            STATUS_BOOT:                              p = PAT_BOOT;
            STATUS_USB_ATTACHED, STATUS_USB_DETACHED: p = PAT_NORM_UP;
            STATUS_ERROR:                             p = PAT_ERROR;
            STATUS_QUEUE_WAIT:                        p = PAT_QUEUE;
            STATUS_WIFI_DOWN:                         p = PAT_WIFI;
            default:                                  p = PAT_IDLE;
         endcase
      end
      return p;
   endfunction

   // Work out which pattern step runs on a tick whose wait has run out, folding
   // the ends of patterns and the next pick into the same pass.
   always_comb begin
      ramp_end    = is_ramp(pat_ff) && (step_ff >= RAMP_END);
      last_ramp   = (pat_ff == PAT_SETUP3) || (pat_ff == PAT_NORM_DOWN);
      blink_end   = is_blink(pat_ff) && (STEP_W'(blink_len(pat_ff)) <= step_ff);
      entry_next  = entry_ff & ~(blink_end && (pat_ff == PAT_ENTRY));
      status_next = (blink_end && (pat_ff == PAT_BOOT)) ? STATUS_USB_ATTACHED : status_ff;

      if (ramp_end && !last_ramp) begin
         cand_pat  = pattern_type'(pat_ff + 4'd1);
         cand_step = '0;
      end else begin
         cand_pat  = pat_ff;
         cand_step = step_ff;
      end

      need_pick = !(is_ramp(pat_ff) || is_blink(pat_ff)) || blink_end
                  || (ramp_end && last_ramp)
                  || (is_ramp(cand_pat) && (is_setup_ramp(cand_pat) != setup_ff));

      if (need_pick) begin
         exec_pat  = pick_pattern(setup_ff, entry_next, wifi_down_ff, status_next);
         exec_step = '0;
      end else begin
         exec_pat  = cand_pat;
         exec_step = cand_step;
      end

      exec_ramp = is_ramp(exec_pat);
      exec_up   = (exec_pat == PAT_SETUP0) || (exec_pat == PAT_SETUP2)
                  || (exec_pat == PAT_NORM_UP);
      level     = exec_up ? {exec_step[COLOR_W-2:0], 1'b0}
                          : LEVEL_TOP - {exec_step[COLOR_W-2:0], 1'b0};
      blink     = blink_entry(blink_start(exec_pat) + exec_step[BLINK_IDX_W-1:0]);

      exec_paint = '0;
      if (exec_ramp) begin
         exec_paint.write = 1'b1;
         if (!is_setup_ramp(exec_pat)) begin
            exec_paint.scaled = 1'b1;
            exec_paint.r = PROD_W'(cfg.normal_red) * PROD_W'(level);
            exec_paint.g = PROD_W'(cfg.normal_green) * PROD_W'(level);
            exec_paint.b = PROD_W'(cfg.normal_blue) * PROD_W'(level);
         end else if ((exec_pat == PAT_SETUP0) || (exec_pat == PAT_SETUP1)) begin
            exec_paint.r = PROD_W'(level >> 2);
            exec_paint.b = PROD_W'(level);
         end else begin
            exec_paint.g = PROD_W'(level >> 1);
            exec_paint.b = PROD_W'(level);
         end
         hold = step_len(is_setup_ramp(exec_pat) ? cfg.setup_step : cfg.normal_step);
      end else begin
         exec_paint.write = blink.write;
         exec_paint.r     = PROD_W'(blink.r);
         exec_paint.g     = PROD_W'(blink.g);
         exec_paint.b     = PROD_W'(blink.b);
         hold             = blink.hold_ms;
      end
   end

   always_comb begin
      status_in    = status_ff;
      setup_in     = setup_ff;
      entry_in     = entry_ff;
      wifi_down_in = wifi_down_ff;
      pat_in       = pat_ff;
      step_in      = step_ff;
      ms_left_in   = ms_left_ff;
      paint        = '0;
      if (accept) begin
         unique case (action_type'(action))
            ACT_TICK: begin
               if (ms_left_ff != '0) begin
                  ms_left_in = ms_left_ff - HOLD_W'(1);
               end else begin
                  pat_in     = exec_pat;
                  step_in    = exec_step + STEP_W'(1);
                  status_in  = status_next;
                  entry_in   = entry_next;
                  ms_left_in = hold - HOLD_W'(1);
                  paint      = exec_paint;
               end
            end
            ACT_STATUS: begin
               status_in = value;
            end
            ACT_SETUP: begin
               if (value[0] && !setup_ff) begin
                  setup_in = 1'b1;
                  entry_in = 1'b1;
               end else if (!value[0] && setup_ff) begin
                  setup_in    = 1'b0;
                  entry_in    = 1'b0;
                  paint.write = 1'b1;
               end
            end
            ACT_WIFI: begin
               wifi_down_in = ~value[0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff    <= STATUS_BOOT;
         setup_ff     <= 1'b0;
         entry_ff     <= 1'b0;
         wifi_down_ff <= 1'b0;
         pat_ff       <= PAT_NONE;
         step_ff      <= '0;
         ms_left_ff   <= '0;
      end else begin
         status_ff    <= status_in;
         setup_ff     <= setup_in;
         entry_ff     <= entry_in;
         wifi_down_ff <= wifi_down_in;
         pat_ff       <= pat_in;
         step_ff      <= step_in;
         ms_left_ff   <= ms_left_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/slps_color.sv
`timescale 1ns / 1ps
`default_nettype none

module slps_color
   import slps_pkg::*;
#(
   parameter int LEVEL_MAX = LEVEL_MAX_DEFAULT
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire paint_type          paint,
   output logic                    take,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [COLOR_W-1:0]      rsp_red,
   output logic [COLOR_W-1:0]      rsp_green,
   output logic [COLOR_W-1:0]      rsp_blue,
   output logic                    rsp_refresh
);

   // Division by the full ramp level as a multiplication by its rounded-up
   // reciprocal, exact for every product of two bytes.
   localparam int LEVEL_LOG   = $clog2(LEVEL_MAX);
   localparam int RECIP_SHIFT = PROD_W + LEVEL_LOG;
   localparam int MUL_W       = 2 * PROD_W + 1;
   localparam longint unsigned RECIP =
      ((64'd1 << RECIP_SHIFT) + 64'(LEVEL_MAX) - 64'd1) / 64'(LEVEL_MAX);

   logic               valid_ff, valid_in;
   logic [COLOR_W-1:0] red_ff, red_in;
   logic [COLOR_W-1:0] green_ff, green_in;
   logic [COLOR_W-1:0] blue_ff, blue_in;
   logic               refresh_ff, refresh_in;
   logic               load;

   function automatic logic [COLOR_W-1:0] channel(input logic              scaled,
                                                  input logic [PROD_W-1:0] x);
      logic [MUL_W-1:0] full;
      full = MUL_W'(x) * MUL_W'(RECIP);
      return scaled ? full[RECIP_SHIFT +: COLOR_W] : x[COLOR_W-1:0];
   endfunction

   always_comb begin
      take       = ~valid_ff | rsp_ready;
      load       = in_valid & take;
      valid_in   = load | (valid_ff & ~rsp_ready);
      red_in     = red_ff;
      green_in   = green_ff;
      blue_in    = blue_ff;
      refresh_in = refresh_ff;
      if (load) begin
         refresh_in = paint.write;
         if (paint.write) begin
            red_in   = channel(paint.scaled, paint.r);
            green_in = channel(paint.scaled, paint.g);
            blue_in  = channel(paint.scaled, paint.b);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         red_ff     <= '0;
         green_ff   <= '0;
         blue_ff    <= '0;
         refresh_ff <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         red_ff     <= red_in;
         green_ff   <= green_in;
         blue_ff    <= blue_in;
         refresh_ff <= refresh_in;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_red     = red_ff;
   assign rsp_green   = green_ff;
   assign rsp_blue    = blue_ff;
   assign rsp_refresh = refresh_ff;

endmodule

`default_nettype wire

// File: dv/status_led_pattern_sequencer_unit_test.sv
`timescale 1ns / 1ps

module status_led_pattern_sequencer_unit_test;
   import slps_pkg::*;

   localparam int LEVEL_TOP  = LEVEL_MAX_DEFAULT;
   localparam int RAMP_STEPS = LEVEL_TOP / 2 + 1;
   localparam int PHASE_ITEMS = 350;
   localparam logic [STATUS_W-1:0] STATUS_IDLE_LOW  = 3'd6;
   localparam logic [STATUS_W-1:0] STATUS_IDLE_HIGH = 3'd7;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [STATUS_W-1:0] value;
   } led_req_type;

   typedef struct packed {
      logic [COLOR_W-1:0] r;
      logic [COLOR_W-1:0] g;
      logic [COLOR_W-1:0] b;
      logic               refresh;
   } led_view_type;

   typedef struct packed {
      logic               on;
      logic [COLOR_W-1:0] r;
      logic [COLOR_W-1:0] g;
      logic [COLOR_W-1:0] b;
      logic [HOLD_W-1:0]  hold;
   } flash_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [ACTION_W-1:0] req_action = '0;
   logic [STATUS_W-1:0] req_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [COLOR_W-1:0] rsp_red, rsp_green, rsp_blue;
   logic rsp_refresh;
   logic csr_wen = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   status_led_pattern_sequencer_unit #(.LEVEL_MAX(LEVEL_TOP)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_red(rsp_red),
      .rsp_green(rsp_green),
      .rsp_blue(rsp_blue),
      .rsp_refresh(rsp_refresh),
      .csr_wen(csr_wen),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   int cfg_red = 6;
   int cfg_green = 87;
   int cfg_blue = 33;
   int cfg_normal_step = 40;
   int cfg_setup_step = 30;

   logic [STATUS_W-1:0] model_status = STATUS_BOOT;
   bit setup_mode = 1'b0;
   bit entry_wait = 1'b0;
   bit wifi_lost = 1'b0;
   pattern_type pattern = PAT_NONE;
   int step_pos = 0;
   int hold_left = 0;
   logic [COLOR_W-1:0] led_r = '0, led_g = '0, led_b = '0;
   bit painted = 1'b0;

   led_req_type req_backlog[$];
   led_view_type led_expected[$];
   led_req_type next_req;
   int mismatches = 0;
   int results_seen = 0;
   int send_gap = 0, send_calm = 0;
   int take_gap = 0, take_calm = 0;

   task automatic note_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
   endtask

   function automatic void paint(input int r, input int g, input int b);
      led_r = r[COLOR_W-1:0];
      led_g = g[COLOR_W-1:0];
      led_b = b[COLOR_W-1:0];
      painted = 1'b1;
   endfunction

   function automatic flash_type flash_at(input int idx);
      flash_type f;
      case (idx)
         0, 2, 4: f = '{1'b1, 8'd0, 8'd0, 8'd64, 10'd120};
         1, 3, 5: f = '{1'b1, 8'd0, 8'd0, 8'd0, 10'd120};
         6:       f = '{1'b1, 8'd96, 8'd0, 8'd24, 10'd200};
         7:       f = '{1'b1, 8'd0, 8'd0, 8'd0, 10'd800};
         8:       f = '{1'b1, 8'd0, 8'd64, 8'd0, 10'd50};
         9:       f = '{1'b1, 8'd0, 8'd0, 8'd0, 10'd500};
         10, 12:  f = '{1'b1, 8'd64, 8'd0, 8'd0, 10'd100};
         11:      f = '{1'b1, 8'd0, 8'd0, 8'd0, 10'd200};
         13:      f = '{1'b1, 8'd0, 8'd0, 8'd0, 10'd800};
         14:      f = '{1'b1, 8'd48, 8'd0, 8'd48, 10'd150};
         15:      f = '{1'b1, 8'd0, 8'd0, 8'd0, 10'd500};
         default: f = '{1'b0, 8'd0, 8'd0, 8'd0, 10'd500};
      endcase
      return f;
   endfunction

   function automatic void choose_pattern();
      step_pos = 0;
      if (setup_mode)
         pattern = entry_wait ? PAT_ENTRY : PAT_SETUP0;
      else if (wifi_lost)
         pattern = PAT_WIFI;
      else begin
         case (model_status)
            STATUS_BOOT: pattern = PAT_BOOT;
            STATUS_USB_ATTACHED, STATUS_USB_DETACHED: pattern = PAT_NORM_UP;
            STATUS_ERROR: pattern = PAT_ERROR;
            STATUS_QUEUE_WAIT: pattern = PAT_QUEUE;
            STATUS_WIFI_DOWN: pattern = PAT_WIFI;
            default: pattern = PAT_IDLE;
         endcase
      end
   endfunction

   // Runs one piece of the LED sequence and returns the hold it loads, or 0.
   function automatic int advance_sequence();
      bit is_setup, rising;
      int lv, first, count, len;
      flash_type f;
      if (pattern == PAT_NONE) begin
         choose_pattern();
         return 0;
      end
      if (pattern >= PAT_SETUP0 && pattern <= PAT_NORM_DOWN) begin
         is_setup = pattern <= PAT_SETUP3;
         rising = ((int'(pattern) - int'(PAT_SETUP0)) % 2) == 0;
         if (step_pos >= RAMP_STEPS) begin
            step_pos = 0;
            if (pattern == PAT_SETUP3 || pattern == PAT_NORM_DOWN)
               pattern = PAT_NONE;
            else
               pattern = pattern_type'(int'(pattern) + 1);
            return 0;
         end
         if (is_setup != setup_mode) begin
            pattern = PAT_NONE;
            step_pos = 0;
            return 0;
         end
         lv = rising ? 2 * step_pos : LEVEL_TOP - 2 * step_pos;
         if (!is_setup)
            paint(cfg_red * lv / LEVEL_TOP, cfg_green * lv / LEVEL_TOP,
                  cfg_blue * lv / LEVEL_TOP);
         else if (pattern < PAT_SETUP2)
            paint(lv / 4, 0, lv);
         else
            paint(0, lv / 2, lv);
         step_pos++;
         len = is_setup ? cfg_setup_step : cfg_normal_step;
         return (len == 0) ? 1 : len;
      end
      case (pattern)
         PAT_ENTRY: begin first = 0; count = 6; end
         PAT_WIFI:  begin first = 6; count = 2; end
         PAT_BOOT:  begin first = 8; count = 2; end
         PAT_ERROR: begin first = 10; count = 4; end
         PAT_QUEUE: begin first = 14; count = 2; end
         PAT_IDLE:  begin first = 16; count = 1; end
         default: begin
            pattern = PAT_NONE;
            step_pos = 0;
            return 0;
         end
      endcase
      if (step_pos >= count) begin
         if (pattern == PAT_ENTRY) entry_wait = 1'b0;
         if (pattern == PAT_BOOT) model_status = STATUS_USB_ATTACHED;
         pattern = PAT_NONE;
         step_pos = 0;
         return 0;
      end
      f = flash_at(first + step_pos);
      if (f.on) paint(f.r, f.g, f.b);
      step_pos++;
      return int'(f.hold);
   endfunction

   function automatic void predict_led(input logic [ACTION_W-1:0] act,
                                       input logic [STATUS_W-1:0] val);
      bit flag;
      int guard;
      led_view_type s;
      flag = val[0];
      painted = 1'b0;
      case (act)
         ACT_TICK: begin
            if (hold_left == 0) begin
               for (guard = 0; guard < 32 && hold_left == 0; guard++)
                  hold_left = advance_sequence();
               if (hold_left == 0) hold_left = 1;
            end
            hold_left--;
         end
         ACT_STATUS: model_status = val;
         ACT_SETUP: begin
            if (flag && !setup_mode) begin
               setup_mode = 1'b1;
               entry_wait = 1'b1;
            end else if (!flag && setup_mode) begin
               setup_mode = 1'b0;
               entry_wait = 1'b0;
               paint(0, 0, 0);
            end
         end
         ACT_WIFI: wifi_lost = !flag;
         default: ;
      endcase
      s = '{led_r, led_g, led_b, painted};
      led_expected.push_back(s);
   endfunction

   function automatic led_req_type random_request(input int event_pct);
      led_req_type it;
      int roll;
      roll = $urandom_range(0, 99);
      it.value = STATUS_W'($urandom_range(0, 7));
      if (roll >= event_pct)
         it.action = ACT_TICK;
      else if (roll < event_pct * 2 / 5)
         it.action = ACT_STATUS;
      else if (roll < event_pct * 7 / 10)
         it.action = ACT_SETUP;
      else begin
         it.action = ACT_WIFI;
         if ($urandom_range(0, 3) != 0) it.value[0] = 1'b1;
      end
      return it;
   endfunction

   function automatic void queue_request(input logic [ACTION_W-1:0] act,
                                         input logic [STATUS_W-1:0] val);
      led_req_type it;
      it.action = act;
      it.value = val;
      req_backlog.push_back(it);
   endfunction

   task automatic write_setting(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_NORMAL_RED:   cfg_red = int'(data[COLOR_W-1:0]);
         CSR_NORMAL_GREEN: cfg_green = int'(data[COLOR_W-1:0]);
         CSR_NORMAL_BLUE:  cfg_blue = int'(data[COLOR_W-1:0]);
         CSR_NORMAL_STEP:  cfg_normal_step = int'(data);
         CSR_SETUP_STEP:   cfg_setup_step = int'(data);
         default: ;
      endcase
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      while (req_backlog.size() != 0 || req_valid || led_expected.size() != 0)
         @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready)
            predict_led(req_action, req_value);
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (req_backlog.size() > 0) begin
               next_req = req_backlog.pop_front();
               req_action <= next_req.action;
               req_value <= next_req.value;
               req_valid <= 1'b1;
               if (send_calm > 0)
                  send_calm--;
               else if ($urandom_range(0, 39) == 0)
                  send_calm = $urandom_range(10, 50);
               else
                  send_gap = $urandom_range(0, 3);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         take_gap = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (led_expected.size() == 0) begin
               note_mismatch($sformatf("result %0d unexpected: %0d %0d %0d refresh %0d",
                  results_seen, rsp_red, rsp_green, rsp_blue, rsp_refresh));
            end else begin
               led_view_type want;
               want = led_expected.pop_front();
               if (rsp_red !== want.r)
                  note_mismatch($sformatf("result %0d red got %0d want %0d",
                     results_seen, rsp_red, want.r));
               if (rsp_green !== want.g)
                  note_mismatch($sformatf("result %0d green got %0d want %0d",
                     results_seen, rsp_green, want.g));
               if (rsp_blue !== want.b)
                  note_mismatch($sformatf("result %0d blue got %0d want %0d",
                     results_seen, rsp_blue, want.b));
               if (rsp_refresh !== want.refresh)
                  note_mismatch($sformatf("result %0d refresh got %0d want %0d",
                     results_seen, rsp_refresh, want.refresh));
            end
            if (take_calm > 0)
               take_calm--;
            else if ($urandom_range(0, 39) == 0)
               take_calm = $urandom_range(10, 50);
            else
               take_gap = $urandom_range(0, 3);
         end
         if (take_gap > 0) begin
            take_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      #2_000_000;
      $display("status_led_pattern_sequencer_unit regression: fail");
      $finish;
   end

   initial begin
      int ph, n;
      int event_pct[5];
      event_pct = '{12, 4, 4, 12, 6};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Every request kind, every status code and both senses of each flag.
      queue_request(ACT_TICK, 3'd0);
      queue_request(ACT_TICK, 3'd7);
      queue_request(ACT_STATUS, STATUS_BOOT);
      queue_request(ACT_WIFI, 3'd0);
      queue_request(ACT_WIFI, 3'd7);
      queue_request(ACT_SETUP, 3'd1);
      queue_request(ACT_SETUP, 3'd3);
      queue_request(ACT_TICK, 3'd5);
      queue_request(ACT_SETUP, 3'd0);
      queue_request(ACT_SETUP, 3'd6);
      queue_request(ACT_STATUS, STATUS_USB_ATTACHED);
      queue_request(ACT_STATUS, STATUS_USB_DETACHED);
      queue_request(ACT_STATUS, STATUS_ERROR);
      queue_request(ACT_STATUS, STATUS_QUEUE_WAIT);
      queue_request(ACT_STATUS, STATUS_IDLE_HIGH);
      queue_request(ACT_STATUS, STATUS_IDLE_LOW);
      queue_request(ACT_WIFI, 3'd2);
      queue_request(ACT_TICK, 3'd2);
      queue_request(ACT_WIFI, 3'd5);
      queue_request(ACT_STATUS, STATUS_WIFI_DOWN);
      queue_request(ACT_TICK, 3'd1);
      queue_request(ACT_TICK, 3'd4);

      for (ph = 0; ph < 5; ph++) begin
         if (ph > 0) begin
            wait_for_drain();
            repeat (4) @(posedge clock);
            case (ph)
               1: begin
                  write_setting(CSR_NORMAL_RED, 10'd255);
                  write_setting(CSR_NORMAL_GREEN, 10'd255);
                  write_setting(CSR_NORMAL_BLUE, 10'd255);
                  write_setting(CSR_NORMAL_STEP, 10'd1);
                  write_setting(CSR_SETUP_STEP, 10'd1);
               end
               2: begin
                  write_setting(CSR_NORMAL_RED, 10'd0);
                  write_setting(CSR_NORMAL_GREEN, 10'd0);
                  write_setting(CSR_NORMAL_BLUE, 10'd0);
                  write_setting(CSR_NORMAL_STEP, 10'd0);
                  write_setting(CSR_SETUP_STEP, 10'd0);
               end
               3: begin
                  write_setting(CSR_NORMAL_RED, CSR_DATA_W'($urandom_range(0, 1023)));
                  write_setting(CSR_NORMAL_GREEN, CSR_DATA_W'($urandom_range(0, 1023)));
                  write_setting(CSR_NORMAL_BLUE, CSR_DATA_W'($urandom_range(0, 1023)));
                  write_setting(CSR_NORMAL_STEP, CSR_DATA_W'($urandom_range(1, 3)));
                  write_setting(CSR_SETUP_STEP, CSR_DATA_W'($urandom_range(1, 3)));
               end
               default: begin
                  write_setting(CSR_NORMAL_RED, CSR_DATA_W'($urandom_range(0, 255)));
                  write_setting(CSR_NORMAL_GREEN, CSR_DATA_W'($urandom_range(0, 255)));
                  write_setting(CSR_NORMAL_BLUE, CSR_DATA_W'($urandom_range(0, 255)));
                  write_setting(CSR_NORMAL_STEP, 10'd1023);
                  write_setting(CSR_SETUP_STEP, 10'd1023);
               end
            endcase
            @(negedge clock);
         end
         for (n = 0; n < PHASE_ITEMS; n++)
            req_backlog.push_back(random_request(event_pct[ph]));
      end

      wait_for_drain();
      repeat (6) @(posedge clock);
      if (mismatches == 0)
         $display("status_led_pattern_sequencer_unit regression: pass");
      else
         $display("status_led_pattern_sequencer_unit regression: fail");
      $finish;
   end

endmodule
